// ----- sv/scst_pkg.sv -----
package scst_pkg;

    // Configuration register indexes, as used on the write port.
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_RADIUS   = 2'd2
    } cfg_reg_t;

    // Load enables for the two register stages of a split multiplier.
    typedef struct packed {
        logic load_pp;
        logic load_sum;
    } mul_en_t;

endpackage

// ----- sv/scst_seg_if.sv -----
interface scst_seg_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_start_x;
    logic signed [COORD_WIDTH-1:0] seg_start_y;
    logic signed [COORD_WIDTH-1:0] seg_end_x;
    logic signed [COORD_WIDTH-1:0] seg_end_y;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        input  ready
    );

    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        output ready
    );
endinterface

// ----- sv/scst_res_if.sv -----
interface scst_res_if;
    logic valid;
    logic ready;
    logic slices;
    logic degenerate;

    modport source (
        output valid, slices, degenerate,
        input  ready
    );

    modport sink (
        input  valid, slices, degenerate,
        output ready
    );
endinterface

// ----- sv/scst_cfg.sv -----
module scst_cfg #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [scst_pkg::CFG_IDX_W-1:0]     index,
    input  logic [COORD_WIDTH-1:0]             data,
    output logic [COORD_WIDTH-1:0]             center_x,
    output logic [COORD_WIDTH-1:0]             center_y,
    output logic [2*COORD_WIDTH-3:0]           radius_sq
);
    import scst_pkg::*;

    localparam int RADW = COORD_WIDTH - 1;
    localparam int RSQW = 2 * COORD_WIDTH - 2;

    logic [COORD_WIDTH-1:0] center_x_reg;
    logic [COORD_WIDTH-1:0] center_y_reg;
    logic [RADW-1:0]        radius_reg;
    logic [RSQW-1:0]        radius_sq_reg;
    logic [RSQW-1:0]        radius_sq_next;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(index))
                REG_CENTER_X: center_x_reg <= data;
                REG_CENTER_Y: center_y_reg <= data;
                REG_RADIUS:   radius_reg   <= data[RADW-1:0];
                default:      ;
            endcase
        end
    end

    // The squared radius is computed from the radius register and registered for the datapath.
    assign radius_sq_next = RSQW'(radius_reg) * RSQW'(radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= '0;
        end
        else
        begin
            radius_sq_reg <= radius_sq_next;
        end
    end

    assign center_x  = center_x_reg;
    assign center_y  = center_y_reg;
    assign radius_sq = radius_sq_reg;

endmodule

// ----- sv/scst_mul.sv -----
module scst_mul #(
    parameter int A_WIDTH = 35,
    parameter int B_WIDTH = 35
) (
    input  logic                          clk,
    input  scst_pkg::mul_en_t             en,
    input  logic [A_WIDTH-1:0]            a,
    input  logic [B_WIDTH-1:0]            b,
    output logic [A_WIDTH+B_WIDTH-1:0]    product
);
    import scst_pkg::*;

    localparam int AL = (A_WIDTH + 1) / 2;
    localparam int AH = A_WIDTH - AL;
    localparam int BL = (B_WIDTH + 1) / 2;
    localparam int BH = B_WIDTH - BL;
    localparam int PW = A_WIDTH + B_WIDTH;

    logic [AL-1:0]    a_lo;
    logic [AH-1:0]    a_hi;
    logic [BL-1:0]    b_lo;
    logic [BH-1:0]    b_hi;
    logic [AL+BL-1:0] pp_ll_reg, pp_ll_next;
    logic [AH+BL-1:0] pp_hl_reg, pp_hl_next;
    logic [AL+BH-1:0] pp_lh_reg, pp_lh_next;
    logic [AH+BH-1:0] pp_hh_reg, pp_hh_next;
    logic [PW-1:0]    product_reg, product_next;

    assign a_lo = a[AL-1:0];
    assign a_hi = a[A_WIDTH-1:AL];
    assign b_lo = b[BL-1:0];
    assign b_hi = b[B_WIDTH-1:BL];

    // First stage: four half-width partial products.
    assign pp_ll_next = (AL+BL)'(a_lo) * (AL+BL)'(b_lo);
    assign pp_hl_next = (AH+BL)'(a_hi) * (AH+BL)'(b_lo);
    assign pp_lh_next = (AL+BH)'(a_lo) * (AL+BH)'(b_hi);
    assign pp_hh_next = (AH+BH)'(a_hi) * (AH+BH)'(b_hi);

    // Second stage: shifted sum of the partial products.
    assign product_next = PW'(pp_ll_reg)
                        + (PW'(pp_hl_reg) << AL)
                        + (PW'(pp_lh_reg) << BL)
                        + (PW'(pp_hh_reg) << (AL + BL));

    always_ff @(posedge clk)
    begin
        if (en.load_pp)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_hl_reg <= pp_hl_next;
            pp_lh_reg <= pp_lh_next;
            pp_hh_reg <= pp_hh_next;
        end
        if (en.load_sum)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ----- sv/segment_circle_slice_test.sv -----
// Channel   Dir  Handshake       Payload
// seg       in   valid / ready   seg_start_x, seg_start_y, seg_end_x, seg_end_y
// res       out  valid / ready   slices, degenerate
// cfg       in   cfg_wr_en       cfg_index, cfg_data (no read-back)
//
// One transaction is accepted per cycle while res.ready does not stall the stages;
// a result is presented once its segment has passed through the nine register
// stages, four of which belong to the two pairs of split multipliers (radius and
// cross term, then the far-point squares). Reset clears the stage valid bits and
// the circle registers to zero.
// A stall holds only the stages that are full, so bubbles close up and no
// transaction is lost or repeated.
module segment_circle_slice_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    scst_seg_if.sink                       seg,
    scst_res_if.source                     res,
    input  logic                           cfg_wr_en,
    input  logic [scst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data
);
    import scst_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;       // coordinate differences
    localparam int PW  = 2 * W + 2;   // signed products and dot / cross terms
    localparam int LW  = 2 * W + 1;   // squared length, cross magnitude
    localparam int RW  = 2 * W - 2;   // squared radius
    localparam int KW  = 2 * W + 3;   // far-point bounds
    localparam int SW  = 4 * W + 3;   // discriminant
    localparam int QW  = 4 * W + 4;   // squared bounds
    localparam int NS  = 9;

    // Stage handshake: a stage loads when it is empty or its successor moves.
    logic [NS:1]   vld_reg;
    logic [NS:1]   vld_in;
    logic [NS+1:1] rdy;

    assign rdy[NS+1] = res.ready;
    assign vld_in    = {vld_reg[NS-1:1], seg.valid};

    for (genvar k = 1; k <= NS; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign seg.ready = rdy[1];

    // Circle registers.
    logic [W-1:0]  center_x;
    logic [W-1:0]  center_y;
    logic [RW-1:0] radius_sq;

    scst_cfg #(
        .COORD_WIDTH (W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_wr_en),
        .index     (cfg_index),
        .data      (cfg_data),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius_sq (radius_sq)
    );

    // Stage 1: direction and centre offset from the start point.
    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg;
    logic signed [DW-1:0] dx_next, dy_next, wx_next, wy_next;
    logic                 deg1_reg, deg1_next;

    assign dx_next   = {seg.seg_end_x[W-1], seg.seg_end_x} -
                       {seg.seg_start_x[W-1], seg.seg_start_x};
    assign dy_next   = {seg.seg_end_y[W-1], seg.seg_end_y} -
                       {seg.seg_start_y[W-1], seg.seg_start_y};
    assign wx_next   = {center_x[W-1], center_x} -
                       {seg.seg_start_x[W-1], seg.seg_start_x};
    assign wy_next   = {center_y[W-1], center_y} -
                       {seg.seg_start_y[W-1], seg.seg_start_y};
    assign deg1_next = (seg.seg_start_x == seg.seg_end_x) &&
                       (seg.seg_start_y == seg.seg_end_y);

    // Stage 2: the six coordinate products.
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxw_reg, pyw_reg, pxwy_reg, pywx_reg;
    logic signed [PW-1:0] pxx_next, pyy_next, pxw_next, pyw_next, pxwy_next, pywx_next;
    logic                 deg2_reg;

    assign pxx_next  = PW'(dx_reg) * PW'(dx_reg);
    assign pyy_next  = PW'(dy_reg) * PW'(dy_reg);
    assign pxw_next  = PW'(dx_reg) * PW'(wx_reg);
    assign pyw_next  = PW'(dy_reg) * PW'(wy_reg);
    assign pxwy_next = PW'(dx_reg) * PW'(wy_reg);
    assign pywx_next = PW'(dy_reg) * PW'(wx_reg);

    // Stage 3: squared length, dot product and cross magnitude.
    logic signed [PW-1:0] l2_full, cross_full;
    logic [PW-1:0]        cross_abs;
    logic [LW-1:0]        l2_3_reg, l2_3_next;
    logic signed [PW-1:0] p3_reg, p3_next;
    logic [LW-1:0]        xabs_reg, xabs_next;
    logic                 deg3_reg;

    assign l2_full    = pxx_reg + pyy_reg;
    assign cross_full = pxwy_reg - pywx_reg;
    assign cross_abs  = cross_full[PW-1] ? -cross_full : cross_full;
    assign l2_3_next  = l2_full[LW-1:0];
    assign p3_next    = pxw_reg + pyw_reg;
    assign xabs_next  = cross_abs[LW-1:0];

    // Stages 4 and 5: r^2 * L2 and cross^2.
    logic [RW+LW-1:0]     rrl2;
    logic [2*LW-1:0]      xsq;
    mul_en_t              en_disc;
    logic [LW-1:0]        l2_4_reg, l2_5_reg;
    logic signed [PW-1:0] p4_reg, p5_reg;
    logic                 deg4_reg, deg5_reg;

    assign en_disc = '{load_pp: rdy[4], load_sum: rdy[5]};

    scst_mul #(
        .A_WIDTH (RW),
        .B_WIDTH (LW)
    ) u_mul_rrl2 (
        .clk     (clk),
        .en      (en_disc),
        .a       (radius_sq),
        .b       (l2_3_reg),
        .product (rrl2)
    );

    scst_mul #(
        .A_WIDTH (LW),
        .B_WIDTH (LW)
    ) u_mul_xsq (
        .clk     (clk),
        .en      (en_disc),
        .a       (xabs_reg),
        .b       (xabs_reg),
        .product (xsq)
    );

    // Stage 6: discriminant and the two far-point bounds.
    logic signed [SW-1:0] s6_reg, s6_next;
    logic                 spos6_reg, spos6_next;
    logic signed [KW-1:0] l2_ext, p_ext, k1_next, k2_next;
    logic signed [KW-1:0] k1_reg, k2_reg;
    logic                 k1neg6_reg, k1neg6_next, k2pos6_reg, k2pos6_next;
    logic                 deg6_reg;

    assign s6_next     = SW'(rrl2) - SW'(xsq);
    assign spos6_next  = !s6_next[SW-1] && (s6_next != '0);
    assign l2_ext      = KW'(l2_5_reg);
    assign p_ext       = {p5_reg[PW-1], p5_reg};
    assign k1_next     = l2_ext - p_ext;
    assign k2_next     = -(l2_ext + p_ext);
    assign k1neg6_next = k1_next[KW-1];
    assign k2pos6_next = !k2_next[KW-1] && (k2_next != '0);

    // Stages 7 and 8: squares of the bounds.
    logic [QW-1:0]        k1sq, k2sq;
    mul_en_t              en_bound;
    logic signed [SW-1:0] s7_reg, s8_reg;
    logic                 spos7_reg, spos8_reg;
    logic                 k1neg7_reg, k1neg8_reg, k2pos7_reg, k2pos8_reg;
    logic                 deg7_reg, deg8_reg;

    assign en_bound = '{load_pp: rdy[7], load_sum: rdy[8]};

    scst_mul #(
        .A_WIDTH (KW - 1),
        .B_WIDTH (KW - 1)
    ) u_mul_k1 (
        .clk     (clk),
        .en      (en_bound),
        .a       (k1_reg[KW-2:0]),
        .b       (k1_reg[KW-2:0]),
        .product (k1sq)
    );

    scst_mul #(
        .A_WIDTH (KW - 1),
        .B_WIDTH (KW - 1)
    ) u_mul_k2 (
        .clk     (clk),
        .en      (en_bound),
        .a       (k2_reg[KW-2:0]),
        .b       (k2_reg[KW-2:0]),
        .product (k2sq)
    );

    // Stage 9: final decision into the output register.
    logic [QW-1:0] s_mag;
    logic          slices_reg, slices_next;
    logic          deg9_reg;

    assign s_mag       = QW'(s8_reg[SW-2:0]);
    assign slices_next = !deg8_reg && spos8_reg && !k1neg8_reg &&
                         !(k1sq < s_mag) && !(k2pos8_reg && (s_mag < k2sq));

    // Datapath registers load together with their stage valid bit.
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            deg1_reg <= deg1_next;
        end
        if (rdy[2])
        begin
            pxx_reg  <= pxx_next;
            pyy_reg  <= pyy_next;
            pxw_reg  <= pxw_next;
            pyw_reg  <= pyw_next;
            pxwy_reg <= pxwy_next;
            pywx_reg <= pywx_next;
            deg2_reg <= deg1_reg;
        end
        if (rdy[3])
        begin
            l2_3_reg <= l2_3_next;
            p3_reg   <= p3_next;
            xabs_reg <= xabs_next;
            deg3_reg <= deg2_reg;
        end
        if (rdy[4])
        begin
            l2_4_reg <= l2_3_reg;
            p4_reg   <= p3_reg;
            deg4_reg <= deg3_reg;
        end
        if (rdy[5])
        begin
            l2_5_reg <= l2_4_reg;
            p5_reg   <= p4_reg;
            deg5_reg <= deg4_reg;
        end
        if (rdy[6])
        begin
            s6_reg     <= s6_next;
            spos6_reg  <= spos6_next;
            k1_reg     <= k1_next;
            k2_reg     <= k2_next;
            k1neg6_reg <= k1neg6_next;
            k2pos6_reg <= k2pos6_next;
            deg6_reg   <= deg5_reg;
        end
        if (rdy[7])
        begin
            s7_reg     <= s6_reg;
            spos7_reg  <= spos6_reg;
            k1neg7_reg <= k1neg6_reg;
            k2pos7_reg <= k2pos6_reg;
            deg7_reg   <= deg6_reg;
        end
        if (rdy[8])
        begin
            s8_reg     <= s7_reg;
            spos8_reg  <= spos7_reg;
            k1neg8_reg <= k1neg7_reg;
            k2pos8_reg <= k2pos7_reg;
            deg8_reg   <= deg7_reg;
        end
        if (rdy[9])
        begin
            slices_reg <= slices_next;
            deg9_reg   <= deg8_reg;
        end
    end

    assign res.valid      = vld_reg[NS];
    assign res.slices     = slices_reg;
    assign res.degenerate = deg9_reg;

endmodule
